FILE: sv/tdlp_pkg.sv
// Package for the three-field decimal line parser.
// Holds the sizing constants, the item and code types, and the byte classifier.
// Depends on nothing; every other file of the block imports it.
package tdlp_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int FIELD_COUNT = 3;
    localparam int OUT_BITS    = 64;
    localparam int COUNT_BITS  = $clog2(FIELD_COUNT + 2);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TOO_FEW   = 3'd1,
        ERR_EXTRA     = 3'd2,
        ERR_NON_DIGIT = 3'd3,
        ERR_OVERFLOW  = 3'd4
    } error_t;

    typedef enum logic [1:0] {
        DERR_NONE      = 2'd0,
        DERR_NON_DIGIT = 2'd1,
        DERR_OVERFLOW  = 2'd2
    } digit_error_t;

    typedef struct packed {
        logic       eol;
        logic       gap;
        logic       digit_ok;
        logic [3:0] digit;
    } token_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic token_item_t classify(input logic opcode, input logic [7:0] char_byte);
        token_item_t item;
        item.eol      = (opcode == OP_EOL);
        item.gap      = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
                        (char_byte == CH_CR) || (char_byte == CH_VT) ||
                        (char_byte == CH_FF);
        item.digit_ok = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
        item.digit    = char_byte[3:0];
        return item;
    endfunction

endpackage

FILE: sv/tdlp_if.sv
// Stream interfaces of the line parser: byte input channel and result channel.
// Each carries valid, ready and the payload; depends on tdlp_pkg.
interface tdlp_in_if import tdlp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_byte;

    modport source (output valid, output opcode, output char_byte, input ready);
    modport sink (input valid, input opcode, input char_byte, output ready);
endinterface

interface tdlp_out_if import tdlp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                line_ok;
    logic [2:0]          error_code;
    logic [OUT_BITS-1:0] first_number;
    logic [OUT_BITS-1:0] second_number;
    logic [OUT_BITS-1:0] third_number;

    modport source (output valid, output line_ok, output error_code, output first_number,
                    output second_number, output third_number, input ready);
    modport sink (input valid, input line_ok, input error_code, input first_number,
                  input second_number, input third_number, output ready);
endinterface

FILE: sv/tdlp_front.sv
// Front end of the line parser: accepts input beats and classifies each byte.
// Pushes classified items into the queue; depends on tdlp_pkg and tdlp_if.
module tdlp_front import tdlp_pkg::*; (
    tdlp_in_if.sink       line_in,
    input  queue_status_t q_status,
    output logic          push,
    output token_item_t   push_item
);

    assign line_in.ready = !q_status.full;
    assign push          = line_in.valid && !q_status.full;
    assign push_item     = classify(line_in.opcode, line_in.char_byte);

endmodule

FILE: sv/tdlp_queue.sv
// Short queue of classified items between the front and back ends.
// Accepts a push and a pop in the same cycle; depends on tdlp_pkg.
module tdlp_queue import tdlp_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  token_item_t   push_item,
    input  logic          pop,
    output token_item_t   head_item,
    output queue_status_t status
);

    token_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign status.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/tdlp_back.sv
// Back end of the line parser: token state, decimal accumulation and the result register.
// Pops classified items from the queue; depends on tdlp_pkg and tdlp_if.
module tdlp_back import tdlp_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  token_item_t   head_item,
    output logic          pop,
    tdlp_out_if.source    result_out
);

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  inside_reg, inside_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] first_reg, first_next;
    logic [VALUE_BITS-1:0] second_reg, second_next;
    digit_error_t          derr_reg, derr_next;

    logic                  out_valid_reg;
    logic                  out_ok_reg, out_ok_next;
    error_t                out_err_reg, out_err_next;
    logic [OUT_BITS-1:0]   out_first_reg, out_first_next;
    logic [OUT_BITS-1:0]   out_second_reg, out_second_next;
    logic [OUT_BITS-1:0]   out_third_reg, out_third_next;

    logic                  out_free;
    logic [VALUE_BITS-1:0] acc_base;
    logic [VALUE_BITS+3:0] scaled;

    assign out_free = !out_valid_reg || result_out.ready;
    assign pop      = !q_status.empty && (!head_item.eol || out_free);

    assign acc_base = inside_reg ? acc_reg : '0;
    assign scaled   = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
                    + (VALUE_BITS + 4)'(head_item.digit);

    always_comb
    begin
        count_next      = count_reg;
        inside_next     = inside_reg;
        acc_next        = acc_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        derr_next       = derr_reg;
        out_ok_next     = 1'b0;
        out_err_next    = ERR_NONE;
        out_first_next  = '0;
        out_second_next = '0;
        out_third_next  = '0;

        if (head_item.eol || head_item.gap)
        begin
            if (inside_reg)
            begin
                if (count_reg == COUNT_BITS'(1))
                begin
                    first_next = acc_reg;
                end
                else if (count_reg == COUNT_BITS'(2))
                begin
                    second_next = acc_reg;
                end
                inside_next = 1'b0;
            end
        end
        else
        begin
            if (!inside_reg)
            begin
                inside_next = 1'b1;
                acc_next    = '0;
                if (count_reg <= COUNT_BITS'(FIELD_COUNT))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            if ((count_next <= COUNT_BITS'(FIELD_COUNT)) && (derr_reg == DERR_NONE))
            begin
                if (!head_item.digit_ok)
                begin
                    derr_next = DERR_NON_DIGIT;
                end
                else if (|scaled[VALUE_BITS+3:VALUE_BITS])
                begin
                    derr_next = DERR_OVERFLOW;
                end
                else
                begin
                    acc_next = scaled[VALUE_BITS-1:0];
                end
            end
        end

        if (head_item.eol)
        begin
            if (count_reg < COUNT_BITS'(FIELD_COUNT))
            begin
                out_err_next = ERR_TOO_FEW;
            end
            else if (count_reg > COUNT_BITS'(FIELD_COUNT))
            begin
                out_err_next = ERR_EXTRA;
            end
            else
            begin
                case (derr_reg)
                    DERR_NONE:      out_err_next = ERR_NONE;
                    DERR_NON_DIGIT: out_err_next = ERR_NON_DIGIT;
                    DERR_OVERFLOW:  out_err_next = ERR_OVERFLOW;
                    default:        out_err_next = ERR_NONE;
                endcase
            end
            out_ok_next = (out_err_next == ERR_NONE);
            if (out_ok_next)
            begin
                out_first_next  = OUT_BITS'(first_next);
                out_second_next = (FIELD_COUNT >= 2) ? OUT_BITS'(second_next) : '0;
                out_third_next  = OUT_BITS'(acc_reg);
            end
            count_next  = '0;
            inside_next = 1'b0;
            acc_next    = '0;
            first_next  = '0;
            second_next = '0;
            derr_next   = DERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            inside_reg    <= 1'b0;
            acc_reg       <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            derr_reg      <= DERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                count_reg  <= count_next;
                inside_reg <= inside_next;
                acc_reg    <= acc_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                derr_reg   <= derr_next;
            end
            if (pop && head_item.eol)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_item.eol)
        begin
            out_ok_reg     <= out_ok_next;
            out_err_reg    <= out_err_next;
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            out_third_reg  <= out_third_next;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.line_ok       = out_ok_reg;
    assign result_out.error_code    = out_err_reg;
    assign result_out.first_number  = out_first_reg;
    assign result_out.second_number = out_second_reg;
    assign result_out.third_number  = out_third_reg;

endmodule

FILE: sv/three_field_decimal_line_parser.sv
// Top level of the three-field decimal line parser.
// Instantiates the front end, the item queue and the back end; depends on tdlp_pkg and tdlp_if.
//
// Usage:
// The line_in channel takes one beat per byte of a text line (opcode 0, byte in char_byte)
// and then one end-of-line beat (opcode 1). Space, tab, CR, VT and FF separate tokens.
// The result_out channel gives one beat per line: line_ok with the three decimal values,
// or an error code (too few tokens, extra token, non-digit, overflow) with zero values.
// Throughput is one beat per cycle on line_in, with no gaps between lines, while result_out
// is not stalled. The front end classifies each byte in the cycle it is accepted and writes
// it to a two-entry queue; the back end updates the token state one item per cycle while
// the queue holds items and an end-of-line item finds the result register free. Each digit is a
// multiply by ten and an add. An end-of-line beat passes the queue and the result register.
// When the receiver stalls, the result waits in its register while byte beats keep
// flowing; a second end-of-line beat then waits in the queue, and line_in drops ready
// once the queue fills. Reset clears the queue, the line state and the result valid.
module three_field_decimal_line_parser import tdlp_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    tdlp_in_if.sink    line_in,
    tdlp_out_if.source result_out
);

    queue_status_t q_status;
    logic          push;
    logic          pop;
    token_item_t   push_item;
    token_item_t   head_item;

    tdlp_front u_front (
        .line_in   (line_in),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    tdlp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    tdlp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_item  (head_item),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

FILE: verif/three_field_decimal_line_parser_tb.sv
// Testbench for the three-field decimal line parser: drives text lines byte by byte and
// checks every result beat against a line tracker kept inside the bench.
// Depends on tdlp_pkg, tdlp_if and the three_field_decimal_line_parser top level.
module three_field_decimal_line_parser_tb;

    import tdlp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [OUT_BITS-1:0] VALUE_LIMIT = {OUT_BITS{1'b1}} >> (OUT_BITS - VALUE_BITS);

    typedef struct packed {
        logic                line_ok;
        error_t              code;
        logic [OUT_BITS-1:0] first;
        logic [OUT_BITS-1:0] second;
        logic [OUT_BITS-1:0] third;
    } line_result_t;

    logic clk = 1'b0;
    logic rst_n;

    tdlp_in_if  line_in();
    tdlp_out_if result_out();

    three_field_decimal_line_parser u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_in    (line_in),
        .result_out (result_out)
    );

    line_result_t        pending_lines[$];
    line_result_t        oldest_line;
    logic [7:0]          line_bytes[$];

    int                  field_count;
    bit                  in_field;
    logic [OUT_BITS-1:0] field_value;
    logic [OUT_BITS-1:0] first_value;
    logic [OUT_BITS-1:0] second_value;
    digit_error_t        digit_fault;

    int unsigned         mismatches = 0;
    int unsigned         cycle_count = 0;
    int unsigned         beats_sent = 0;
    bit                  bursty_sender = 1'b0;
    int unsigned         burst_left = 0;
    int unsigned         rx_stall_pct = 0;
    int unsigned         rx_hold_left = 0;
    int unsigned         rx_run_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit is_separator(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) ||
               (ch == CH_VT) || (ch == CH_FF);
    endfunction

    task automatic clear_line_state();
        field_count  = 0;
        in_field     = 1'b0;
        field_value  = '0;
        first_value  = '0;
        second_value = '0;
        digit_fault  = DERR_NONE;
    endtask

    task automatic close_field();
        if (in_field)
        begin
            if (field_count == 1)
                first_value = field_value;
            else if (field_count == 2)
                second_value = field_value;
            in_field = 1'b0;
        end
    endtask

    task automatic parse_line_beat(input logic op, input logic [7:0] ch);
        logic [OUT_BITS-1:0] digit;
        line_result_t        res;
        if (op == OP_CHAR)
        begin
            if (is_separator(ch))
            begin
                close_field();
            end
            else
            begin
                if (!in_field)
                begin
                    in_field    = 1'b1;
                    field_value = '0;
                    if (field_count <= FIELD_COUNT)
                        field_count++;
                end
                if (field_count <= FIELD_COUNT && digit_fault == DERR_NONE)
                begin
                    if (ch < CH_ZERO || ch > CH_NINE)
                    begin
                        digit_fault = DERR_NON_DIGIT;
                    end
                    else
                    begin
                        digit = {{(OUT_BITS-8){1'b0}}, ch} - {{(OUT_BITS-8){1'b0}}, CH_ZERO};
                        if (field_value > (VALUE_LIMIT - digit) / 10)
                            digit_fault = DERR_OVERFLOW;
                        else
                            field_value = field_value * 10 + digit;
                    end
                end
            end
        end
        else
        begin
            close_field();
            if (field_count < FIELD_COUNT)
                res.code = ERR_TOO_FEW;
            else if (field_count > FIELD_COUNT)
                res.code = ERR_EXTRA;
            else if (digit_fault == DERR_NON_DIGIT)
                res.code = ERR_NON_DIGIT;
            else if (digit_fault == DERR_OVERFLOW)
                res.code = ERR_OVERFLOW;
            else
                res.code = ERR_NONE;
            res.line_ok = (res.code == ERR_NONE);
            if (res.line_ok)
            begin
                res.first  = first_value;
                res.second = (FIELD_COUNT >= 2) ? second_value : '0;
                res.third  = field_value;
            end
            else
            begin
                res.first  = '0;
                res.second = '0;
                res.third  = '0;
            end
            pending_lines.push_back(res);
            clear_line_state();
        end
    endtask

    task automatic sender_idle(input int unsigned cycles);
        line_in.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_beat(input logic op, input logic [7:0] ch);
        line_in.valid     <= 1'b1;
        line_in.opcode    <= op;
        line_in.char_byte <= ch;
        do
        begin
            @(posedge clk);
        end
        while (!line_in.ready);
        parse_line_beat(op, ch);
        beats_sent++;
        if (bursty_sender)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                sender_idle($urandom_range(1, 6));
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            send_beat(OP_CHAR, line_bytes[i]);
        send_beat(OP_EOL, 8'($urandom_range(0, 255)));
        line_bytes.delete();
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++)
            line_bytes.push_back(text[i]);
    endtask

    task automatic send_text_line(input string text);
        push_text(text);
        send_line();
    endtask

    task automatic drain_results();
        sender_idle(1);
        while (pending_lines.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_digit();
        logic [7:0] d;
        d = 8'($urandom_range(0, 9));
        line_bytes.push_back(CH_ZERO + d);
    endtask

    task automatic push_gaps(input int unsigned lo, input int unsigned hi);
        int unsigned n;
        n = $urandom_range(lo, hi);
        repeat (n)
        begin
            case ($urandom_range(0, 4))
                0: line_bytes.push_back(CH_SPACE);
                1: line_bytes.push_back(CH_TAB);
                2: line_bytes.push_back(CH_CR);
                3: line_bytes.push_back(CH_VT);
                default: line_bytes.push_back(CH_FF);
            endcase
        end
    endtask

    task automatic push_token(input bit noisy);
        int unsigned kind;
        int unsigned len;
        logic [7:0]  junk;
        kind = $urandom_range(0, 9);
        if (kind == 7)
        begin
            push_text("1844674407370955161");
            push_digit();
        end
        else
        begin
            if (kind <= 5)
                len = $urandom_range(1, 6);
            else if (kind == 6)
                len = $urandom_range(7, 19);
            else if (kind == 8)
                len = $urandom_range(20, 21);
            else
                len = $urandom_range(1, 3);
            repeat (len)
            begin
                if (noisy && $urandom_range(0, 7) == 0)
                begin
                    junk = 8'($urandom_range(0, 255));
                    line_bytes.push_back(junk);
                end
                else if (kind == 9)
                begin
                    line_bytes.push_back(CH_ZERO);
                end
                else
                begin
                    push_digit();
                end
            end
        end
    endtask

    task automatic build_random_line();
        int unsigned fields;
        bit          noisy;
        noisy  = ($urandom_range(0, 99) < 30);
        fields = noisy ? $urandom_range(0, 5) : FIELD_COUNT;
        push_gaps(0, 2);
        for (int f = 0; f < fields; f++)
        begin
            push_token(noisy);
            if (f + 1 < fields)
                push_gaps(1, 3);
        end
        push_gaps(0, 2);
    endtask

    task automatic test_directed_lines();
        bursty_sender = 1'b0;
        send_text_line("0 0 0");
        send_text_line("18446744073709551615 1 2");
        send_text_line("18446744073709551616 1 2");
        send_text_line("7 8 99999999999999999999");
        send_line();
        line_bytes = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
        send_line();
        send_text_line("1 2");
        send_text_line("1 2 3 4");
        send_text_line("1 2 3 x/");
        send_text_line("/ 2 :");
        send_text_line("99999999999999999999 a 1");
        send_text_line("a 99999999999999999999 1");
        line_bytes = '{CH_CR, "5", CH_TAB, "6", CH_VT, "7", CH_FF};
        send_line();
        push_text("1 2 ");
        line_bytes.push_back(8'hFF);
        send_line();
        push_text("1 ");
        line_bytes.push_back(8'h00);
        push_text(" 3");
        send_line();
        send_text_line("007 0010 12345");
        drain_results();
    endtask

    task automatic test_random_lines(input int unsigned stall_pct, input bit bursty,
                                     input int unsigned beat_goal);
        int unsigned start;
        rx_stall_pct  <= stall_pct;
        bursty_sender = bursty;
        burst_left    = 0;
        start         = beats_sent;
        while (beats_sent - start < beat_goal)
        begin
            build_random_line();
            send_line();
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        rx_stall_pct  <= 0;
        rx_hold_left  <= 80;
        bursty_sender = 1'b0;
        for (int n = 0; n < 6; n++)
        begin
            if (n % 2 == 0)
                push_text("7 8 9");
            else
                build_random_line();
            send_line();
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            result_out.ready <= 1'b0;
            rx_hold_left     <= rx_hold_left - 1;
        end
        else if (rx_run_left != 0)
        begin
            rx_run_left <= rx_run_left - 1;
        end
        else
        begin
            result_out.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            rx_run_left      <= $urandom_range(0, 5);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
        begin
            if (pending_lines.size() == 0)
            begin
                $error("result beat with no line pending");
                mismatches++;
            end
            else
            begin
                oldest_line = pending_lines.pop_front();
                if (result_out.line_ok !== oldest_line.line_ok)
                begin
                    $error("line_ok: expected %0d, actual %0d",
                           oldest_line.line_ok, result_out.line_ok);
                    mismatches++;
                end
                if (result_out.error_code !== oldest_line.code)
                begin
                    $error("error_code: expected %0d, actual %0d",
                           oldest_line.code, result_out.error_code);
                    mismatches++;
                end
                if (result_out.first_number !== oldest_line.first)
                begin
                    $error("first_number: expected %0d, actual %0d",
                           oldest_line.first, result_out.first_number);
                    mismatches++;
                end
                if (result_out.second_number !== oldest_line.second)
                begin
                    $error("second_number: expected %0d, actual %0d",
                           oldest_line.second, result_out.second_number);
                    mismatches++;
                end
                if (result_out.third_number !== oldest_line.third)
                begin
                    $error("third_number: expected %0d, actual %0d",
                           oldest_line.third, result_out.third_number);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("three_field_decimal_line_parser_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        line_in.valid     = 1'b0;
        line_in.opcode    = OP_CHAR;
        line_in.char_byte = 8'h00;
        result_out.ready  = 1'b1;
        clear_line_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_lines();
        test_random_lines(0, 1'b0, 250);
        test_random_lines(25, 1'b1, 350);
        test_random_lines(60, 1'b1, 400);
        test_backpressure();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_lines.size() == 0)
            $display("three_field_decimal_line_parser_tb: done, clean");
        else
            $display("three_field_decimal_line_parser_tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/tdlp_pkg.sv
sv/tdlp_if.sv
sv/tdlp_front.sv
sv/tdlp_queue.sv
sv/tdlp_back.sv
sv/three_field_decimal_line_parser.sv
verif/three_field_decimal_line_parser_tb.sv
